// ===== rtl/cws_pkg.sv =====
// shared constants for the css whitespace stripper
// character codes and default pending store depth, no dependencies
`default_nettype none

package cws_pkg;

    localparam int unsigned PENDING_DEPTH = 32;

    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_QUOTE  = 8'd39;
    localparam logic [7:0] CH_COLON  = 8'd58;
    localparam logic [7:0] CH_SEMI   = 8'd59;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_LBRACE = 8'd123;
    localparam logic [7:0] CH_RBRACE = 8'd125;

endpackage

`default_nettype wire

// ===== rtl/css_whitespace_stripper_core.sv =====
// Stylesheet whitespace stripper: one input byte per transfer, zero or more output bytes.
// Held whitespace lives in a synchronous pending memory. A byte that is dropped, held or
// passed straight through is handled in the cycle that accepts it. A byte that releases n held
// whitespace bytes goes through the accepting cycle, then a read state (for the memory read
// latency) and a send state for each held byte, then a last state that sends the byte itself.
// Output stalls hold the send and last states; no new byte is accepted until the release ends.
// Uses cws_pkg for character codes and the default store depth.
`default_nettype none

module css_whitespace_stripper_core #(
    parameter int unsigned PENDING_DEPTH = cws_pkg::PENDING_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_char
    input  wire logic       s_tuser,   // start_text
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_char
    output logic            m_tlast    // last_out
);

    localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);
    localparam int unsigned AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_SEND = 4'b0100,
        ST_LAST = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic            in_string_reg, in_string_next;
    logic            keep_reg, keep_next;
    logic            prev_bslash_reg, prev_bslash_next;
    logic            prev_opens_reg, prev_opens_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   rd_addr_reg, rd_addr_next;
    logic [7:0]      hold_char_reg, hold_char_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_char_reg, out_char_next;
    logic            out_last_reg, out_last_next;

    logic [7:0]      mem [PENDING_DEPTH];
    logic [7:0]      rd_data_reg;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;

    logic            out_free, s_fire;
    logic            in_str_cur, keep_cur, bslash_cur, opens_cur;
    logic [CW-1:0]   count_cur;
    logic            in_str_new, is_ws, emit, is_break, keep_mid, flush;
    logic [CW-1:0]   idx_inc;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    // state as seen by this byte, after a possible start of text
    assign in_str_cur = s_tuser ? 1'b0 : in_string_reg;
    assign keep_cur   = s_tuser ? 1'b1 : keep_reg;
    assign bslash_cur = s_tuser ? 1'b0 : prev_bslash_reg;
    assign opens_cur  = s_tuser ? 1'b0 : prev_opens_reg;
    assign count_cur  = s_tuser ? '0 : count_reg;

    assign in_str_new = (s_tdata == cws_pkg::CH_QUOTE) ? (!in_str_cur || bslash_cur)
                                                        : in_str_cur;
    assign is_ws      = (s_tdata == cws_pkg::CH_SPACE) || (s_tdata == cws_pkg::CH_TAB)
                     || (s_tdata == cws_pkg::CH_NL);
    assign emit       = !is_ws || in_str_new;
    assign is_break   = (s_tdata == cws_pkg::CH_LBRACE) || (s_tdata == cws_pkg::CH_SEMI);
    assign keep_mid   = is_break ? 1'b0 : keep_cur;
    assign flush      = emit && keep_mid && (count_cur != '0);
    assign idx_inc    = idx_reg + CW'(1);

    always_comb
    begin
        state_next       = state_reg;
        in_string_next   = in_string_reg;
        keep_next        = keep_reg;
        prev_bslash_next = prev_bslash_reg;
        prev_opens_next  = prev_opens_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        rd_addr_next     = rd_addr_reg;
        hold_char_next   = hold_char_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_char_next    = out_char_reg;
        out_last_next    = out_last_reg;
        wr_en            = 1'b0;
        wr_addr          = count_cur[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    in_string_next   = in_str_new;
                    prev_bslash_next = (s_tdata == cws_pkg::CH_BSLASH);
                    if (emit)
                    begin
                        keep_next       = opens_cur ? 1'b1 : keep_mid;
                        prev_opens_next = (s_tdata == cws_pkg::CH_RBRACE)
                                       || (s_tdata == cws_pkg::CH_COLON);
                        count_next      = is_break ? '0 : count_cur;
                        hold_char_next  = s_tdata;
                        if (flush)
                        begin
                            idx_next     = '0;
                            rd_addr_next = '0;
                            state_next   = ST_READ;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = s_tdata;
                            out_last_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        keep_next       = keep_cur;
                        prev_opens_next = opens_cur;
                        count_next      = count_cur;
                        if (keep_cur && (count_cur < CW'(PENDING_DEPTH)))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_cur + CW'(1);
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = rd_data_reg;
                    out_last_next  = 1'b0;
                    idx_next       = idx_inc;
                    if (idx_inc == count_reg)
                    begin
                        state_next = ST_LAST;
                    end
                    else
                    begin
                        rd_addr_next = idx_inc[AW-1:0];
                        state_next   = ST_READ;
                    end
                end
            end
            ST_LAST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = hold_char_reg;
                    out_last_next  = 1'b1;
                    count_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pending whitespace memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= s_tdata;
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            in_string_reg   <= 1'b0;
            keep_reg        <= 1'b1;
            prev_bslash_reg <= 1'b0;
            prev_opens_reg  <= 1'b0;
            count_reg       <= '0;
            idx_reg         <= '0;
            rd_addr_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            in_string_reg   <= in_string_next;
            keep_reg        <= keep_next;
            prev_bslash_reg <= prev_bslash_next;
            prev_opens_reg  <= prev_opens_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            rd_addr_reg     <= rd_addr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_char_reg <= hold_char_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

endmodule

`default_nettype wire
